// ===== rtl/core/dlt_pkg.sv =====
// ---------------------------------------------------------------------------
// Dependency lock tracker package
// Shared codes, sequencer states, status types and a helper function.
// ---------------------------------------------------------------------------
package dlt_pkg;

    // Default sizes handed to the top level's parameters.
    localparam int NUM_STREAMS_DEF = 16;
    localparam int STACK_DEPTH_DEF = 8;

    // Fixed field widths.
    localparam int SID_BITS = 4;
    localparam int DEP_BITS = 3;
    localparam int OP_BITS  = 2;
    localparam int ERR_BITS = 3;
    localparam int CNT_BITS = 4;
    localparam int NUM_DEPS = 4;

    localparam logic [CNT_BITS-1:0] HOLD_MAX = 4'd15;

    // Lock operations.
    localparam logic [OP_BITS-1:0] OP_NONE   = 2'd0;
    localparam logic [OP_BITS-1:0] OP_LOCK   = 2'd1;
    localparam logic [OP_BITS-1:0] OP_UNLOCK = 2'd2;
    localparam logic [OP_BITS-1:0] OP_BAD    = 2'd3;

    // Dependencies, in lock order.
    localparam logic [DEP_BITS-1:0] DEP_NONE   = 3'd0;
    localparam logic [DEP_BITS-1:0] DEP_BRANCH = 3'd1;
    localparam logic [DEP_BITS-1:0] DEP_M0     = 3'd2;
    localparam logic [DEP_BITS-1:0] DEP_VCC    = 3'd3;
    localparam logic [DEP_BITS-1:0] DEP_SCC    = 3'd4;

    // Error codes.
    localparam logic [ERR_BITS-1:0] ERR_OK       = 3'd0;
    localparam logic [ERR_BITS-1:0] ERR_ORDER    = 3'd1;
    localparam logic [ERR_BITS-1:0] ERR_RELOCK   = 3'd2;
    localparam logic [ERR_BITS-1:0] ERR_EMPTY    = 3'd3;
    localparam logic [ERR_BITS-1:0] ERR_NOT_LIFO = 3'd4;
    localparam logic [ERR_BITS-1:0] ERR_OVERFLOW = 3'd5;
    localparam logic [ERR_BITS-1:0] ERR_BAD_CODE = 3'd6;

    typedef enum logic [2:0] {
        S_IDLE,
        S_TOP,
        S_RD2,
        S_SCAN,
        S_DONE
    } t_state;

    typedef struct packed {
        logic done;
        logic grant;
    } t_scan_stat;

    // Branch and SCC locks cannot be preempted.
    function automatic logic non_preemptible(input logic [DEP_BITS-1:0] d);
        return (d == DEP_BRANCH) || (d == DEP_SCC);
    endfunction

endpackage

// ===== rtl/core/dlt_stack_mem.sv =====
// ---------------------------------------------------------------------------
// Lock stack memory
// One write port and one registered read port holding every stream's stack.
// ---------------------------------------------------------------------------
module dlt_stack_mem #(
    parameter int ADDR_W = 7,
    parameter int DATA_W = 3
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [DATA_W-1:0] i_wr_data,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [DATA_W-1:0] o_rd_data
);
    logic [DATA_W-1:0] r_mem [2**ADDR_W];
    logic [DATA_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== rtl/core/dlt_scan_unit.sv =====
// ---------------------------------------------------------------------------
// Exclusive-issue rescan unit
// Walks dependency levels downward one per cycle while they are held and preemptible.
// ---------------------------------------------------------------------------
module dlt_scan_unit (
    input  logic                           i_clk,
    input  logic                           i_load,
    input  logic [dlt_pkg::DEP_BITS-1:0]   i_load_dep,
    input  logic                           i_step,
    input  logic [dlt_pkg::NUM_DEPS-1:0]   i_held,
    output dlt_pkg::t_scan_stat            o_stat
);
    import dlt_pkg::*;

    logic [DEP_BITS-1:0] r_lvl;
    logic [DEP_BITS-1:0] n_lvl;
    logic [1:0]          lvl_idx;
    logic                live;

    assign lvl_idx = 2'(r_lvl - 3'd1);
    assign live    = (r_lvl != DEP_NONE) && (r_lvl <= DEP_SCC) && i_held[lvl_idx];

    // The walk ends at the first level that is free, or at a held level that
    // cannot be preempted, which grants exclusive issue.
    assign o_stat.grant = live && non_preemptible(r_lvl);
    assign o_stat.done  = !live || non_preemptible(r_lvl);

    always_comb begin
        n_lvl = r_lvl;
        if (i_load) begin
            n_lvl = i_load_dep;
        end else if (i_step && !o_stat.done) begin
            n_lvl = r_lvl - 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_lvl <= n_lvl;
    end

endmodule

// ===== rtl/core/dependency_lock_tracker_top.sv =====
// ---------------------------------------------------------------------------
// Dependency lock tracker
// Checks and commits ordered dependency locks for instruction streams.
// ---------------------------------------------------------------------------
//  Channel  Direction  Handshake            Word
//  input    in         i_valid / o_stall    mode, stream_id, lock_op, dependency
//  output   out        o_valid / i_stall    blocked, error, exclusive_held,
//                                           exclusive_stream, stack_depth,
//                                           top_dependency
//
// An item passes through S_IDLE, which accepts it, S_TOP, which evaluates it
// with the stream's top lock read from the stack memory, and S_DONE, which
// loads the output register. A committed unlock adds S_RD2, which reads the
// new top lock, and S_SCAN, in which the rescan unit walks the lower levels.
// The stack memory's single read port and the rescan unit set this
// sequence.
// Reset is synchronous and active low; it clears the stack levels, hold
// counts and exclusive-issue state at once, with no clearing pass.
// A stalled result waits in the output register; the next word may be
// accepted meanwhile, and its result waits until the register is free.
// ---------------------------------------------------------------------------
module dependency_lock_tracker_top #(
    parameter int NUM_STREAMS = dlt_pkg::NUM_STREAMS_DEF,
    parameter int STACK_DEPTH = dlt_pkg::STACK_DEPTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // Input channel
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic                          i_mode,
    input  logic [dlt_pkg::SID_BITS-1:0]  i_stream_id,
    input  logic [dlt_pkg::OP_BITS-1:0]   i_lock_op,
    input  logic [dlt_pkg::DEP_BITS-1:0]  i_dependency,
    // Output channel
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic                          o_blocked,
    output logic [dlt_pkg::ERR_BITS-1:0]  o_error,
    output logic                          o_exclusive_held,
    output logic [dlt_pkg::SID_BITS-1:0]  o_exclusive_stream,
    output logic [dlt_pkg::CNT_BITS-1:0]  o_stack_depth,
    output logic [dlt_pkg::DEP_BITS-1:0]  o_top_dependency
);
    import dlt_pkg::*;

    // Only streams that the 4-bit stream number can reach need storage.
    localparam int NS_EFF  = (NUM_STREAMS > (1 << SID_BITS)) ? (1 << SID_BITS) : NUM_STREAMS;
    localparam int SID_W   = (NS_EFF > 1) ? $clog2(NS_EFF) : 1;
    localparam int SLOT_W  = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int LV_W    = $clog2(STACK_DEPTH + 1);
    localparam int ADDR_W  = SID_W + SLOT_W;
    localparam int LV_ENT  = 1 << SID_W;
    localparam int DEPTH_W = (LV_W > CNT_BITS) ? LV_W : CNT_BITS;

    // Sequencer
    t_state r_state;
    t_state n_state;

    // Latched input word
    logic                r_mode;
    logic [SID_BITS-1:0] r_stream;
    logic [OP_BITS-1:0]  r_op;
    logic [DEP_BITS-1:0] r_dep;

    // Tracker state
    logic [LV_W-1:0]     r_levels [LV_ENT];
    logic [CNT_BITS-1:0] r_hold   [NUM_DEPS];
    logic [SID_BITS-1:0] r_owner  [NUM_DEPS];
    logic                r_excl_valid;
    logic [SID_BITS-1:0] r_excl_owner;

    // Per-item results
    logic                r_blocked;
    logic [ERR_BITS-1:0] r_err;
    logic [DEP_BITS-1:0] r_new_top;

    // Output register
    logic                r_o_valid;
    logic                r_o_blocked;
    logic [ERR_BITS-1:0] r_o_error;
    logic                r_o_excl;
    logic [SID_BITS-1:0] r_o_excl_sid;
    logic [CNT_BITS-1:0] r_o_depth;
    logic [DEP_BITS-1:0] r_o_top;

    // Stack memory interface
    logic                mem_wr_en;
    logic [ADDR_W-1:0]   mem_wr_addr;
    logic [ADDR_W-1:0]   mem_rd_addr;
    logic [DEP_BITS-1:0] mem_rd_data;

    // Rescan unit interface
    logic                scan_load;
    logic                scan_step;
    logic [DEP_BITS-1:0] scan_load_dep;
    logic [NUM_DEPS-1:0] held_vec;
    t_scan_stat          scan_stat;

    // Decoded working values
    logic                accept;
    logic                in_stall;
    logic                slot_free;
    logic                out_load;
    logic [SID_W-1:0]    in_sidx;
    logic [LV_W-1:0]     in_lv;
    logic [LV_W-1:0]     in_lv_m1;
    logic [SID_W-1:0]    cur_sidx;
    logic                cur_good;
    logic [LV_W-1:0]     cur_lv;
    logic [LV_W-1:0]     cur_lv_m1;
    logic [LV_W-1:0]     cur_lv_m2;
    logic [LV_W-1:0]     cur_lv_p1;
    logic [DEP_BITS-1:0] cur_top;
    logic [1:0]          dep_idx;
    logic [1:0]          top_idx;
    logic [CNT_BITS-1:0] dep_h;
    logic [SID_BITS-1:0] dep_own;
    logic [CNT_BITS-1:0] top_h;
    logic [SID_BITS-1:0] top_own;
    logic                ev_blocked;
    logic [ERR_BITS-1:0] ev_err;
    logic                commit_lock;
    logic                commit_unlock;
    logic [DEPTH_W-1:0]  depth_ext;

    // ------------------------------------------------------------------
    // Submodules
    // ------------------------------------------------------------------
    dlt_stack_mem #(
        .ADDR_W (ADDR_W),
        .DATA_W (DEP_BITS)
    ) u_mem (
        .i_clk     (i_clk),
        .i_wr_en   (mem_wr_en),
        .i_wr_addr (mem_wr_addr),
        .i_wr_data (r_dep),
        .i_rd_addr (mem_rd_addr),
        .o_rd_data (mem_rd_data)
    );

    dlt_scan_unit u_scan (
        .i_clk      (i_clk),
        .i_load     (scan_load),
        .i_load_dep (scan_load_dep),
        .i_step     (scan_step),
        .i_held     (held_vec),
        .o_stat     (scan_stat)
    );

    // ------------------------------------------------------------------
    // Address and index arithmetic
    // ------------------------------------------------------------------
    assign in_sidx   = i_stream_id[SID_W-1:0];
    assign in_lv     = r_levels[in_sidx];
    assign in_lv_m1  = in_lv - LV_W'(1);

    assign cur_sidx  = r_stream[SID_W-1:0];
    assign cur_good  = 32'(r_stream) < NUM_STREAMS;
    assign cur_lv    = r_levels[cur_sidx];
    assign cur_lv_m1 = cur_lv - LV_W'(1);
    assign cur_lv_m2 = cur_lv - LV_W'(2);
    assign cur_lv_p1 = cur_lv + LV_W'(1);

    // An empty stack has no top lock; the memory word is then ignored.
    assign cur_top   = (cur_lv == '0) ? DEP_NONE : mem_rd_data;

    assign dep_idx   = 2'(r_dep - 3'd1);
    assign top_idx   = 2'(cur_top - 3'd1);
    assign dep_h     = r_hold[dep_idx];
    assign dep_own   = r_owner[dep_idx];
    assign top_h     = r_hold[top_idx];
    assign top_own   = r_owner[top_idx];

    assign mem_wr_addr = {cur_sidx, cur_lv[SLOT_W-1:0]};

    always_comb begin
        for (int i = 0; i < NUM_DEPS; i++) begin
            held_vec[i] = (r_hold[i] != '0);
        end
    end

    // ------------------------------------------------------------------
    // Item evaluation, valid while the sequencer is in S_TOP
    // ------------------------------------------------------------------
    always_comb begin
        ev_err        = ERR_OK;
        ev_blocked    = 1'b0;
        commit_lock   = 1'b0;
        commit_unlock = 1'b0;
        if (!cur_good || (r_op == OP_BAD) || (r_dep > DEP_SCC) ||
            ((r_op == OP_LOCK) && (r_dep == DEP_NONE))) begin
            ev_err = ERR_BAD_CODE;
        end else begin
            // Ordering is checked first; blocking applies only to items that
            // are in order.
            if ((r_dep != DEP_NONE) && (cur_top > r_dep)) begin
                ev_err = ERR_ORDER;
            end else if (r_excl_valid) begin
                ev_blocked = (r_excl_owner != r_stream);
            end else if ((r_op == OP_LOCK) && (dep_h != '0)) begin
                ev_blocked = (dep_own != r_stream);
            end

            if ((ev_err == ERR_OK) && !ev_blocked) begin
                if (r_op == OP_LOCK) begin
                    // A held dependency may only be stacked again by its owner
                    // while it is that stream's top lock.
                    if ((dep_h != '0) && ((cur_top != r_dep) || (dep_own != r_stream))) begin
                        ev_err = ERR_RELOCK;
                    end else if ((cur_lv >= LV_W'(STACK_DEPTH)) || (dep_h >= HOLD_MAX)) begin
                        ev_err = ERR_OVERFLOW;
                    end else begin
                        commit_lock = r_mode;
                    end
                end else if (r_op == OP_UNLOCK) begin
                    if (cur_lv == '0) begin
                        ev_err = ERR_EMPTY;
                    end else if ((r_dep != DEP_NONE) && (r_dep != cur_top)) begin
                        ev_err = ERR_NOT_LIFO;
                    end else if ((cur_top == DEP_NONE) || (cur_top > DEP_SCC) ||
                                 (top_h == '0) || (top_own != r_stream)) begin
                        ev_err = ERR_NOT_LIFO;
                    end else begin
                        commit_unlock = r_mode;
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Sequencer: next state
    // ------------------------------------------------------------------
    assign slot_free = !r_o_valid || !i_stall;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_state = S_TOP;
                end
            end
            S_TOP: begin
                n_state = commit_unlock ? S_RD2 : S_DONE;
            end
            S_RD2: begin
                n_state = S_SCAN;
            end
            S_SCAN: begin
                if (scan_stat.done) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (slot_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Sequencer: outputs
    // ------------------------------------------------------------------
    always_comb begin
        in_stall      = 1'b1;
        mem_wr_en     = 1'b0;
        mem_rd_addr   = {in_sidx, in_lv_m1[SLOT_W-1:0]};
        scan_load     = 1'b0;
        scan_step     = 1'b0;
        out_load      = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                in_stall = 1'b0;
            end
            S_TOP: begin
                // Fetch the top lock left after a possible unlock.
                mem_rd_addr = {cur_sidx, cur_lv_m2[SLOT_W-1:0]};
                mem_wr_en   = commit_lock;
            end
            S_RD2: begin
                scan_load = 1'b1;
            end
            S_SCAN: begin
                scan_step = 1'b1;
            end
            S_DONE: begin
                out_load = slot_free;
            end
            default: begin
                in_stall = 1'b1;
            end
        endcase
    end

    assign accept        = i_valid && !in_stall;
    assign scan_load_dep = (cur_lv == '0) ? DEP_NONE : mem_rd_data;

    // ------------------------------------------------------------------
    // Control registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_excl_valid <= 1'b0;
            r_excl_owner <= '0;
            r_o_valid    <= 1'b0;
            for (int i = 0; i < LV_ENT; i++) begin
                r_levels[i] <= '0;
            end
            for (int i = 0; i < NUM_DEPS; i++) begin
                r_hold[i] <= '0;
            end
        end else begin
            r_state <= n_state;

            if ((r_state == S_TOP) && commit_lock) begin
                r_levels[cur_sidx] <= cur_lv_p1;
                r_hold[dep_idx]    <= dep_h + CNT_BITS'(1);
                if (non_preemptible(r_dep)) begin
                    r_excl_valid <= 1'b1;
                    r_excl_owner <= r_stream;
                end
            end

            if ((r_state == S_TOP) && commit_unlock) begin
                r_levels[cur_sidx] <= cur_lv_m1;
                r_hold[top_idx]    <= top_h - CNT_BITS'(1);
                r_excl_valid       <= 1'b0;
                r_excl_owner       <= '0;
            end

            // The rescan grants exclusive issue back to the unlocking stream
            // when a lower held level cannot be preempted.
            if ((r_state == S_SCAN) && scan_stat.grant) begin
                r_excl_valid <= 1'b1;
                r_excl_owner <= r_stream;
            end

            if (out_load) begin
                r_o_valid <= 1'b1;
            end else if (!i_stall) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Payload registers
    // ------------------------------------------------------------------
    assign depth_ext = DEPTH_W'(cur_lv);

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_mode   <= i_mode;
            r_stream <= i_stream_id;
            r_op     <= i_lock_op;
            r_dep    <= i_dependency;
        end

        if ((r_state == S_TOP) && commit_lock) begin
            r_owner[dep_idx] <= r_stream;
        end

        if (r_state == S_TOP) begin
            r_blocked <= ev_blocked;
            r_err     <= ev_err;
            r_new_top <= commit_lock ? r_dep : cur_top;
        end

        if (r_state == S_RD2) begin
            r_new_top <= scan_load_dep;
        end

        if (out_load) begin
            r_o_blocked  <= r_blocked;
            r_o_error    <= r_err;
            r_o_excl     <= r_excl_valid;
            r_o_excl_sid <= r_excl_valid ? r_excl_owner : '0;
            r_o_depth    <= cur_good ? depth_ext[CNT_BITS-1:0] : '0;
            r_o_top      <= cur_good ? r_new_top : DEP_NONE;
        end
    end

    // ------------------------------------------------------------------
    // Ports
    // ------------------------------------------------------------------
    assign o_stall            = in_stall;
    assign o_valid            = r_o_valid;
    assign o_blocked          = r_o_blocked;
    assign o_error            = r_o_error;
    assign o_exclusive_held   = r_o_excl;
    assign o_exclusive_stream = r_o_excl_sid;
    assign o_stack_depth      = r_o_depth;
    assign o_top_dependency   = r_o_top;

endmodule

// ===== rtl/core/dlt_checker.sv =====
// ---------------------------------------------------------------------------
// Dependency lock tracker checker
// Port-level assertions on the tracker, attached to the top level by bind.
// ---------------------------------------------------------------------------
module dlt_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_valid,
    input logic                          o_stall,
    input logic                          o_valid,
    input logic                          i_stall,
    input logic                          o_blocked,
    input logic [dlt_pkg::ERR_BITS-1:0]  o_error,
    input logic                          o_exclusive_held,
    input logic [dlt_pkg::SID_BITS-1:0]  o_exclusive_stream
);
    import dlt_pkg::*;

    // One word at a time: the input side closes right after an accept.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall)
        else $error("input accepted on consecutive cycles");

    // A word waiting on a stalled output stays offered.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> o_valid)
        else $error("output word dropped while stalled");

    // A blocked item never reports an error.
    a_blocked_no_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_blocked && (o_error != ERR_OK)))
        else $error("blocked word carries an error code");

    // The exclusive stream number reads zero when nothing is held.
    a_excl_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_exclusive_held) |-> (o_exclusive_stream == '0))
        else $error("exclusive stream set without exclusive issue");

    // Error code seven is never produced.
    a_err_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_error != 3'd7))
        else $error("undefined error code");

endmodule

bind dependency_lock_tracker_top dlt_checker u_dlt_checker (.*);
